/* src/ist_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ist_pkg
// shared types and constants of the id slot table set
// ----------------------------------------------------------------------------
package ist_pkg;

    localparam int ID_W  = 32;
    localparam int CNT_W = 6;

    typedef enum logic [2:0] {
        REQ_ADD   = 3'd0,
        REQ_HAS   = 3'd1,
        REQ_DEL   = 3'd2,
        REQ_FIRST = 3'd3,
        REQ_NEXT  = 3'd4
    } req_t;

    // request word as it travels down the chain of cells
    typedef struct packed {
        logic            live;
        req_t            req;
        logic [ID_W-1:0] id;
        logic            done;
        logic [ID_W-1:0] hit_id;
    } wave_t;

    // result word
    typedef struct packed {
        logic             found;
        logic [ID_W-1:0]  id_out;
        logic [CNT_W-1:0] entry_count;
        logic             is_empty;
        logic             is_full;
    } rsp_t;

endpackage
`default_nettype wire

/* src/ist_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ist_req_if
// request channel: valid, ready and the request word
// ----------------------------------------------------------------------------
interface ist_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [31:0] id_in;

    modport source (output valid, output req_type, output id_in, input ready);
    modport sink   (input valid, input req_type, input id_in, output ready);
endinterface
`default_nettype wire

/* src/ist_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ist_rsp_if
// response channel: valid, ready and the result word
// ----------------------------------------------------------------------------
interface ist_rsp_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] id_out;
    logic [5:0]  entry_count;
    logic        is_empty;
    logic        is_full;

    modport source (output valid, output found, output id_out, output entry_count,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input found, input id_out, input entry_count,
                    input is_empty, input is_full, output ready);
endinterface
`default_nettype wire

/* src/ist_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ist_cell
// one slot of the table; acts on the passing request word and hands it on
// ----------------------------------------------------------------------------
module ist_cell
    import ist_pkg::*;
#(
    parameter int CUR_W = 6,
    parameter int INDEX = 0
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire  [CUR_W-1:0] cursor,
    input  wave_t            wave_in,
    input  wire  [CUR_W-1:0] idx_in,
    output wave_t            wave_out,
    output logic [CUR_W-1:0] idx_out
);

    localparam logic [CUR_W-1:0] MY_IDX = CUR_W'(INDEX);

    logic [ID_W-1:0]  slot_reg;
    logic [ID_W-1:0]  slot_next;
    logic             live_reg;
    wave_t            wave_reg;
    wave_t            wave_next;
    logic [CUR_W-1:0] idx_reg;
    logic [CUR_W-1:0] idx_next;
    logic             take;
    logic             occupied;

    assign occupied = (slot_reg != '0);

    always_comb
    begin
        take = 1'b0;
        case (wave_in.req) inside
            REQ_ADD:          take = (wave_in.id != '0) && !occupied;
            REQ_HAS, REQ_DEL: take = (wave_in.id != '0) && (slot_reg == wave_in.id);
            REQ_FIRST:        take = occupied;
            REQ_NEXT:         take = occupied && (MY_IDX > cursor);
            default:          take = 1'b0;
        endcase
        take = take && wave_in.live && !wave_in.done;

        slot_next = slot_reg;
        wave_next = wave_in;
        idx_next  = idx_in;
        if (take)
        begin
            wave_next.done = 1'b1;
            idx_next       = MY_IDX;
            case (wave_in.req) inside
                REQ_ADD:              slot_next = wave_in.id;
                REQ_DEL:              slot_next = '0;
                REQ_FIRST, REQ_NEXT:  wave_next.hit_id = slot_reg;
                default:              slot_next = slot_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            live_reg <= 1'b0;
        end
        else
        begin
            slot_reg <= slot_next;
            live_reg <= wave_in.live;
        end
    end

    always_ff @(posedge clk)
    begin
        wave_reg <= wave_next;
        idx_reg  <= idx_next;
    end

    always_comb
    begin
        wave_out      = wave_reg;
        wave_out.live = live_reg;
    end

    assign idx_out = idx_reg;

endmodule
`default_nettype wire

/* src/id_slot_table_set.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// id_slot_table_set
// table of SLOTS nonzero 32-bit ids with add, has, delete, first and next
// ----------------------------------------------------------------------------
// usage
//   req channel takes one word: req_type (add, has, delete, first, next) and
//   id_in; rsp channel returns one word per request: found, id_out,
//   entry_count, is_empty and is_full after the request
//   the table is a row of SLOTS cells, one slot each; a request word enters
//   cell 0 and moves one cell per clock, and the lowest cell that can act on
//   it does so and marks it done, which gives the lowest-index priority
//   from acceptance to rsp.valid a request passes the entry register, which
//   loads at the accepting edge, then the register of each cell in turn and
//   the output register, or the skid register while the output is full
//   a new request is taken only once the request word of the last one has
//   left the cell row; one request is in the row at a time
//   reset clears every slot at once, the count to zero and the walk cursor
//   to zero; the block takes a request in the first cycle after reset
//   a stalled receiver: the next request is still accepted while a result
//   waits; its result parks in a skid register, and while that is full
//   req.ready stays low as well
// ----------------------------------------------------------------------------
module id_slot_table_set
    import ist_pkg::*;
#(
    parameter int SLOTS = 32
) (
    input wire         clk,
    input wire         rst_n,
    ist_req_if.sink    req,
    ist_rsp_if.source  rsp
);

    localparam int CUR_W = $clog2(SLOTS + 1);
    localparam logic [CUR_W-1:0] SLOTS_C = CUR_W'(SLOTS);

    // request word chain: entry register feeds cell 0
    wave_t            wave [0:SLOTS];
    logic [CUR_W-1:0] idx  [0:SLOTS];

    logic             in_live_reg;
    wave_t            in_word_reg;
    logic             busy_reg;
    logic             busy_next;
    logic [CUR_W-1:0] count_reg;
    logic [CUR_W-1:0] count_next;
    logic [CUR_W-1:0] cursor_reg;
    logic [CUR_W-1:0] cursor_next;

    logic             rsp_vld_reg;
    logic             rsp_vld_next;
    rsp_t             rsp_word_reg;
    rsp_t             rsp_word_next;
    logic             skid_vld_reg;
    logic             skid_vld_next;
    rsp_t             skid_word_reg;
    rsp_t             skid_word_next;

    logic             accept;
    logic             arrive;
    logic             rsp_take;
    wave_t            fin;
    rsp_t             fin_word;
    logic [CUR_W+5:0] count_ext;

    assign req.ready = !busy_reg && !skid_vld_reg;
    assign accept    = req.valid && req.ready;

    // entry register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_live_reg <= 1'b0;
        end
        else
        begin
            in_live_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_word_reg.live   <= 1'b1;
            in_word_reg.req    <= req_t'(req.req_type);
            in_word_reg.id     <= req.id_in;
            in_word_reg.done   <= 1'b0;
            in_word_reg.hit_id <= '0;
        end
    end

    always_comb
    begin
        wave[0]      = in_word_reg;
        wave[0].live = in_live_reg;
    end
    assign idx[0] = '0;

    // row of slot cells
    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        ist_cell #(
            .CUR_W (CUR_W),
            .INDEX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cursor   (cursor_reg),
            .wave_in  (wave[i]),
            .idx_in   (idx[i]),
            .wave_out (wave[i+1]),
            .idx_out  (idx[i+1])
        );
    end

    // the request word leaves the last cell: settle count and cursor
    assign fin    = wave[SLOTS];
    assign arrive = fin.live;

    always_comb
    begin
        count_next  = count_reg;
        cursor_next = cursor_reg;
        if (arrive)
        begin
            case (fin.req)
                REQ_ADD:   if (fin.done) count_next = count_reg + 1'b1;
                REQ_DEL:   if (fin.done) count_next = count_reg - 1'b1;
                REQ_FIRST: cursor_next = fin.done ? idx[SLOTS] : '0;
                REQ_NEXT:  cursor_next = fin.done ? idx[SLOTS] : SLOTS_C;
                default:   count_next = count_reg;
            endcase
        end
    end

    assign count_ext = {6'b0, count_next};

    always_comb
    begin
        fin_word.found       = fin.done;
        fin_word.id_out      = fin.hit_id;
        fin_word.entry_count = count_ext[CNT_W-1:0];
        fin_word.is_empty    = (count_next == '0);
        fin_word.is_full     = (count_next == SLOTS_C);
    end

    // output register with a skid stage behind it
    assign rsp_take = rsp_vld_reg && rsp.ready;

    always_comb
    begin
        busy_next      = busy_reg;
        rsp_vld_next   = rsp_vld_reg && !rsp_take;
        rsp_word_next  = rsp_word_reg;
        skid_vld_next  = skid_vld_reg;
        skid_word_next = skid_word_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        if (skid_vld_reg && !rsp_vld_next)
        begin
            rsp_vld_next  = 1'b1;
            rsp_word_next = skid_word_reg;
            skid_vld_next = 1'b0;
        end
        if (arrive)
        begin
            busy_next = 1'b0;
            if (!rsp_vld_next)
            begin
                rsp_vld_next  = 1'b1;
                rsp_word_next = fin_word;
            end
            else
            begin
                skid_vld_next  = 1'b1;
                skid_word_next = fin_word;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            count_reg    <= '0;
            cursor_reg   <= '0;
            rsp_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            count_reg    <= count_next;
            cursor_reg   <= cursor_next;
            rsp_vld_reg  <= rsp_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_word_reg  <= rsp_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign rsp.valid       = rsp_vld_reg;
    assign rsp.found       = rsp_word_reg.found;
    assign rsp.id_out      = rsp_word_reg.id_out;
    assign rsp.entry_count = rsp_word_reg.entry_count;
    assign rsp.is_empty    = rsp_word_reg.is_empty;
    assign rsp.is_full     = rsp_word_reg.is_full;

    // checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= SLOTS_C)
        else $error("slot count beyond table size");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= SLOTS_C)
        else $error("walk cursor beyond table size");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> rsp_vld_reg)
        else $error("skid word held while output register is empty");

    a_arrive_busy: assert property (@(posedge clk) disable iff (!rst_n)
        arrive |-> busy_reg)
        else $error("request word left the cell row with no request open");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_live_reg && busy_reg)
        else $error("accepted request did not enter the cell row");

endmodule
`default_nettype wire
